// ===== hw/rtl/qnl_pkg.sv =====
// types and constants shared by the quaternion nlerp unit
package qnl_pkg;

	localparam int COMP_BITS   = 16;
	localparam int FRAC_BITS   = COMP_BITS - 2;
	localparam int WEIGHT_BITS = 17;
	localparam int THR_BITS    = 16;
	localparam int WONE_BITS   = WEIGHT_BITS + 1;

	localparam logic [THR_BITS-1:0]  THR_RESET  = THR_BITS'(1);
	localparam logic [WONE_BITS-1:0] WEIGHT_ONE = WONE_BITS'(65536);

	localparam int PROD_BITS  = 2 * COMP_BITS;
	localparam int DOT_BITS   = PROD_BITS + 2;
	localparam int SCALE_BITS = COMP_BITS + WEIGHT_BITS + 1;
	localparam int BLEND_BITS = SCALE_BITS + 1;
	localparam int MAG_BITS   = COMP_BITS + 16;
	localparam int POS_BITS   = $clog2(MAG_BITS);
	localparam int NORM_BITS  = 31;
	localparam int NORM_TOP   = NORM_BITS - 1;
	localparam int SQ_BITS    = 2 * NORM_BITS;
	localparam int LEN_BITS   = 64;
	localparam int ROOT_BITS  = 32;
	localparam int REM_BITS   = ROOT_BITS + 4;
	localparam int SQ_STEPS   = ROOT_BITS;
	localparam int QUO_BITS   = FRAC_BITS + 1;
	localparam int NUM_BITS   = NORM_BITS + FRAC_BITS + 1;
	localparam int DIV_STEPS  = QUO_BITS;
	localparam int LATENCY    = 7 + SQ_STEPS + 1 + DIV_STEPS + 1;

	typedef logic signed [COMP_BITS-1:0] comp_t;

	typedef struct packed {
		comp_t                  from_x;
		comp_t                  from_y;
		comp_t                  from_z;
		comp_t                  from_w;
		comp_t                  to_x;
		comp_t                  to_y;
		comp_t                  to_z;
		comp_t                  to_w;
		logic [WEIGHT_BITS-1:0] weight;
	} operand_t;

	typedef struct packed {
		comp_t out_x;
		comp_t out_y;
		comp_t out_z;
		comp_t out_w;
		logic  zero_length;
	} result_t;

	typedef struct packed {
		logic       early;
		logic       zero;
		logic [3:0] neg;
		result_t    pass;
	} meta_t;

endpackage

// ===== hw/rtl/quaternion_nlerp_unit.sv =====
// quaternion nlerp unit: early outs, blend, normalize, pipelined sqrt and divide
//
// Normalized linear interpolation of two Q2.14 quaternions, one item per clock.
// An item is transferred when start is high and busy is low; busy is never
// raised, so a new item can be given every cycle. Its result comes out on
// result with a one-cycle done strobe after passing through every pipeline stage;
// the receiver cannot stall, so results must be taken as they come.
// The pipeline has seven front stages (early-out check and
// dot products, blend products, blend and magnitude, leading-one search,
// normalize shift, squares, length sum), 32 stages of the bit-per-stage square
// root, one numerator stage, 15 stages of the bit-per-stage divider in four
// lanes, and the output register. A weight within edge_threshold of 0 or 1
// returns the first or second quaternion as given. A blend of all zeros
// returns zeros with zero_length set. edge_threshold is written through the
// cfg channel, which is always ready; write it only while no item is in flight.
module quaternion_nlerp_unit
	import qnl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  operand_t            operands,
	output logic                done,
	output result_t             result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [THR_BITS-1:0] cfg_data
);

	logic [THR_BITS-1:0] thr_q;

	// the pipeline never holds off
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// ---------------------------------------------------------------- stage 1
	// early-out decision and the four dot-product terms
	comp_t                          in_f [4];
	comp_t                          in_g [4];
	logic                           in_low, in_high;
	logic                           vld_s1;
	meta_t                          meta_s1;
	logic signed [PROD_BITS-1:0]    prod_s1 [4];
	comp_t                          f_s1 [4];
	comp_t                          g_s1 [4];
	logic [WEIGHT_BITS-1:0]         t_s1, omt_s1;

	always_comb begin
		in_f[0] = operands.from_x;
		in_f[1] = operands.from_y;
		in_f[2] = operands.from_z;
		in_f[3] = operands.from_w;
		in_g[0] = operands.to_x;
		in_g[1] = operands.to_y;
		in_g[2] = operands.to_z;
		in_g[3] = operands.to_w;
		in_low  = WONE_BITS'(operands.weight) < WONE_BITS'(thr_q);
		in_high = (WONE_BITS'(operands.weight) + WONE_BITS'(thr_q)) > WEIGHT_ONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1.early            <= in_low || in_high;
		meta_s1.zero             <= 1'b0;
		meta_s1.neg              <= '0;
		meta_s1.pass.out_x       <= in_low ? operands.from_x : operands.to_x;
		meta_s1.pass.out_y       <= in_low ? operands.from_y : operands.to_y;
		meta_s1.pass.out_z       <= in_low ? operands.from_z : operands.to_z;
		meta_s1.pass.out_w       <= in_low ? operands.from_w : operands.to_w;
		meta_s1.pass.zero_length <= 1'b0;
		for (int i = 0; i < 4; i++) begin
			prod_s1[i] <= in_f[i] * in_g[i];
			f_s1[i]    <= in_f[i];
			g_s1[i]    <= in_g[i];
		end
		t_s1   <= operands.weight;
		omt_s1 <= WEIGHT_BITS'(WEIGHT_ONE - WONE_BITS'(operands.weight));
	end

	// ---------------------------------------------------------------- stage 2
	// dot sign and the weighted products
	logic signed [DOT_BITS-1:0]   dot;
	logic                         vld_s2;
	meta_t                        meta_s2;
	logic                         neg_s2;
	logic signed [SCALE_BITS-1:0] pa_s2 [4];
	logic signed [SCALE_BITS-1:0] pb_s2 [4];

	always_comb begin
		dot = '0;
		for (int i = 0; i < 4; i++) begin
			dot = dot + DOT_BITS'(prod_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		meta_s2 <= meta_s1;
		neg_s2  <= dot[DOT_BITS-1];
		for (int i = 0; i < 4; i++) begin
			pa_s2[i] <= $signed({1'b0, omt_s1}) * f_s1[i];
			pb_s2[i] <= $signed({1'b0, t_s1}) * g_s1[i];
		end
	end

	// ---------------------------------------------------------------- stage 3
	// blend, sign and magnitude
	logic signed [BLEND_BITS-1:0] blend [4];
	logic [BLEND_BITS-1:0]        babs  [4];
	meta_t                        meta_d3;
	logic                         vld_s3;
	meta_t                        meta_s3;
	logic [MAG_BITS-1:0]          mag_s3 [4];

	always_comb begin
		meta_d3 = meta_s2;
		for (int i = 0; i < 4; i++) begin
			blend[i] = neg_s2 ? BLEND_BITS'(pa_s2[i]) - BLEND_BITS'(pb_s2[i])
			                  : BLEND_BITS'(pa_s2[i]) + BLEND_BITS'(pb_s2[i]);
			babs[i]  = blend[i][BLEND_BITS-1] ? BLEND_BITS'(-blend[i]) : BLEND_BITS'(blend[i]);
			meta_d3.neg[i] = blend[i][BLEND_BITS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		meta_s3 <= meta_d3;
		for (int i = 0; i < 4; i++) begin
			mag_s3[i] <= babs[i][MAG_BITS-1:0];
		end
	end

	// ---------------------------------------------------------------- stage 4
	// leading one of the largest magnitude (same as that of the or of all four)
	logic [MAG_BITS-1:0] mag_or;
	logic [POS_BITS-1:0] lead;
	meta_t               meta_d4;
	logic                vld_s4;
	meta_t               meta_s4;
	logic [MAG_BITS-1:0] mag_s4 [4];
	logic [POS_BITS-1:0] lead_s4;

	always_comb begin
		mag_or = mag_s3[0] | mag_s3[1] | mag_s3[2] | mag_s3[3];
		lead   = '0;
		for (int b = 0; b < MAG_BITS; b++) begin
			if (mag_or[b]) begin
				lead = POS_BITS'(b);
			end
		end
		meta_d4      = meta_s3;
		meta_d4.zero = (mag_or == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		meta_s4 <= meta_d4;
		mag_s4  <= mag_s3;
		lead_s4 <= lead;
	end

	// ---------------------------------------------------------------- stage 5
	// shared shift puts the leading one at the top of a 31-bit word
	logic [MAG_BITS+NORM_BITS-1:0] wide [4];
	logic                          vld_s5;
	meta_t                         meta_s5;
	logic [NORM_BITS-1:0]          nm_s5 [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (lead_s4 >= POS_BITS'(NORM_TOP)) begin
				wide[i] = (MAG_BITS+NORM_BITS)'(mag_s4[i] >> (lead_s4 - POS_BITS'(NORM_TOP)));
			end else begin
				wide[i] = (MAG_BITS+NORM_BITS)'(mag_s4[i]) << (POS_BITS'(NORM_TOP) - lead_s4);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		meta_s5 <= meta_s4;
		for (int i = 0; i < 4; i++) begin
			nm_s5[i] <= wide[i][NORM_BITS-1:0];
		end
	end

	// ---------------------------------------------------------------- stage 6
	// squares
	logic                 vld_s6;
	meta_t                meta_s6;
	logic [NORM_BITS-1:0] nm_s6 [4];
	logic [SQ_BITS-1:0]   sq_s6 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		meta_s6 <= meta_s5;
		nm_s6   <= nm_s5;
		for (int i = 0; i < 4; i++) begin
			sq_s6[i] <= nm_s5[i] * nm_s5[i];
		end
	end

	// ---------------------------------------------------------------- stage 7
	// squared length
	logic                 vld_s7;
	meta_t                meta_s7;
	logic [NORM_BITS-1:0] nm_s7 [4];
	logic [LEN_BITS-1:0]  len_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		meta_s7 <= meta_s6;
		nm_s7   <= nm_s6;
		len_s7  <= LEN_BITS'(sq_s6[0]) + LEN_BITS'(sq_s6[1])
		         + LEN_BITS'(sq_s6[2]) + LEN_BITS'(sq_s6[3]);
	end

	// ----------------------------------------------------------- square root
	// one root bit per stage, restoring digit recurrence
	logic [SQ_STEPS:0]     sq_vld_s;
	meta_t                 sq_meta_s [SQ_STEPS+1];
	logic [NORM_BITS-1:0]  sq_nm_s   [SQ_STEPS+1][4];
	logic [REM_BITS-1:0]   sq_rem_s  [SQ_STEPS+1];
	logic [ROOT_BITS-1:0]  sq_root_s [SQ_STEPS+1];
	logic [LEN_BITS-1:0]   sq_len_s  [SQ_STEPS+1];

	assign sq_vld_s[0]  = vld_s7;
	assign sq_meta_s[0] = meta_s7;
	assign sq_nm_s[0]   = nm_s7;
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;
	assign sq_len_s[0]  = len_s7;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		logic [REM_BITS-1:0] rem_sh, trial;
		logic                take;

		always_comb begin
			rem_sh = {sq_rem_s[k][REM_BITS-3:0], sq_len_s[k][LEN_BITS-1 -: 2]};
			trial  = REM_BITS'({sq_root_s[k], 2'b01});
			take   = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[k+1] <= 1'b0;
			end else begin
				sq_vld_s[k+1] <= sq_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			sq_meta_s[k+1] <= sq_meta_s[k];
			sq_nm_s[k+1]   <= sq_nm_s[k];
			sq_rem_s[k+1]  <= take ? rem_sh - trial : rem_sh;
			sq_root_s[k+1] <= {sq_root_s[k][ROOT_BITS-2:0], take};
			sq_len_s[k+1]  <= sq_len_s[k] << 2;
		end
	end

	// -------------------------------------------------------- numerator stage
	// n = m * 2^frac + root/2, upper part starts the remainder
	logic [NUM_BITS-1:0]  num [4];
	logic [DIV_STEPS:0]   dv_vld_s;
	meta_t                dv_meta_s [DIV_STEPS+1];
	logic [ROOT_BITS-1:0] dv_root_s [DIV_STEPS+1];
	logic [ROOT_BITS-1:0] dv_rem_s  [DIV_STEPS+1][4];
	logic [QUO_BITS-1:0]  dv_low_s  [DIV_STEPS+1][4];
	logic [QUO_BITS-1:0]  dv_quo_s  [DIV_STEPS+1][4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			num[i] = (NUM_BITS'(sq_nm_s[SQ_STEPS][i]) << FRAC_BITS)
			       + NUM_BITS'(sq_root_s[SQ_STEPS] >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else begin
			dv_vld_s[0] <= sq_vld_s[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		dv_meta_s[0] <= sq_meta_s[SQ_STEPS];
		dv_root_s[0] <= sq_root_s[SQ_STEPS];
		for (int i = 0; i < 4; i++) begin
			dv_rem_s[0][i] <= ROOT_BITS'(num[i] >> QUO_BITS);
			dv_low_s[0][i] <= num[i][QUO_BITS-1:0];
			dv_quo_s[0][i] <= '0;
		end
	end

	// ---------------------------------------------------------------- divider
	// one quotient bit per stage, four lanes sharing the root
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [ROOT_BITS:0] sh   [4];
		logic [ROOT_BITS:0] diff [4];
		logic [3:0]         ge;

		always_comb begin
			for (int i = 0; i < 4; i++) begin
				sh[i]   = {dv_rem_s[k][i], dv_low_s[k][i][QUO_BITS-1]};
				diff[i] = sh[i] - {1'b0, dv_root_s[k]};
				ge[i]   = sh[i] >= {1'b0, dv_root_s[k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_meta_s[k+1] <= dv_meta_s[k];
			dv_root_s[k+1] <= dv_root_s[k];
			for (int i = 0; i < 4; i++) begin
				dv_rem_s[k+1][i] <= ge[i] ? diff[i][ROOT_BITS-1:0] : sh[i][ROOT_BITS-1:0];
				dv_low_s[k+1][i] <= dv_low_s[k][i] << 1;
				dv_quo_s[k+1][i] <= {dv_quo_s[k][i][QUO_BITS-2:0], ge[i]};
			end
		end
	end

	// ----------------------------------------------------------------- output
	// pick early-out, zero-length or normalized result, reapply signs
	comp_t   qv  [4];
	comp_t   sv  [4];
	meta_t   fin_meta;
	result_t res_next;
	logic    done_q;
	result_t result_q;

	always_comb begin
		fin_meta = dv_meta_s[DIV_STEPS];
		for (int i = 0; i < 4; i++) begin
			qv[i] = COMP_BITS'(dv_quo_s[DIV_STEPS][i]);
			sv[i] = fin_meta.neg[i] ? -qv[i] : qv[i];
		end
		if (fin_meta.early) begin
			res_next = fin_meta.pass;
		end else if (fin_meta.zero) begin
			res_next             = '0;
			res_next.zero_length = 1'b1;
		end else begin
			res_next.out_x       = sv[0];
			res_next.out_y       = sv[1];
			res_next.out_z       = sv[2];
			res_next.out_w       = sv[3];
			res_next.zero_length = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_next;
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// every result comes from a start transfer a fixed latency earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching start");

	// zero-length results carry all-zero components
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.zero_length |->
		result.out_x == '0 && result.out_y == '0 && result.out_z == '0 && result.out_w == '0)
		else $error("zero length with nonzero components");

	// a nonzero blend is normalized with its leading one at the top bit
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && !meta_s5.early && !meta_s5.zero |->
		(nm_s5[0][NORM_TOP] || nm_s5[1][NORM_TOP] || nm_s5[2][NORM_TOP] || nm_s5[3][NORM_TOP]))
		else $error("normalize shift missed the top bit");
`endif

endmodule

// ===== test/quaternion_nlerp_unit_tb.sv =====
// self-checking testbench for the quaternion nlerp unit
module quaternion_nlerp_unit_tb
	import qnl_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WEIGHT_FULL = 65536;
	localparam int CLIP_WEIGHT = (1 << WEIGHT_BITS) - 1;
	localparam int MAX_GAP     = 12;
	localparam int WIDE_THR    = 65535;

	// kinds of generated items
	typedef enum int {
		KIND_ANY,
		KIND_UNITISH,
		KIND_OPPOSED,
		KIND_EDGE_WEIGHT
	} item_kind_e;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	operand_t            operands;
	logic                done;
	result_t             result;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [THR_BITS-1:0] cfg_data;

	// sampled at the falling edge, so values are settled between rising edges
	logic    busy_s;

	operand_t pending_items[$];
	result_t  expected_blends[$];
	logic [THR_BITS-1:0] edge_thr;
	int  gap_left;
	int  gap_limit;
	int  error_count;

	quaternion_nlerp_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operands  (operands),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// expected nlerp of one item under a given edge threshold
	function automatic result_t nlerp_expect(operand_t op, logic [THR_BITS-1:0] thr);
		longint      f[4];
		longint      g[4];
		longint      b[4];
		longint      t;
		longint      omt;
		longint      st;
		longint      dot;
		bit [63:0]   m[4];
		bit [63:0]   mx;
		bit [63:0]   len2;
		bit [63:0]   rem;
		bit [63:0]   root;
		bit [63:0]   bitv;
		bit [63:0]   q;
		comp_t       o[4];
		result_t     r;
		int          i;
		f[0] = op.from_x; f[1] = op.from_y; f[2] = op.from_z; f[3] = op.from_w;
		g[0] = op.to_x;   g[1] = op.to_y;   g[2] = op.to_z;   g[3] = op.to_w;
		t = longint'(op.weight);
		r = '0;
		// low early out is tested first
		if (t < longint'(thr)) begin
			r.out_x = op.from_x; r.out_y = op.from_y;
			r.out_z = op.from_z; r.out_w = op.from_w;
			return r;
		end
		if (t > WEIGHT_FULL - longint'(thr)) begin
			r.out_x = op.to_x; r.out_y = op.to_y;
			r.out_z = op.to_z; r.out_w = op.to_w;
			return r;
		end
		dot = 0;
		for (i = 0; i < 4; i++)
			dot += f[i] * g[i];
		st = (dot < 0) ? -t : t;
		omt = WEIGHT_FULL - t;
		mx = 0;
		for (i = 0; i < 4; i++) begin
			b[i] = omt * f[i] + st * g[i];
			m[i] = (b[i] < 0) ? 64'(-b[i]) : 64'(b[i]);
			if (m[i] > mx)
				mx = m[i];
		end
		if (mx == 0) begin
			r.zero_length = 1'b1;
			return r;
		end
		// common shift into [2^30, 2^31)
		while (mx >= (64'd1 << 31)) begin
			mx >>= 1;
			for (i = 0; i < 4; i++)
				m[i] >>= 1;
		end
		while (mx < (64'd1 << 30)) begin
			mx <<= 1;
			for (i = 0; i < 4; i++)
				m[i] <<= 1;
		end
		len2 = 0;
		for (i = 0; i < 4; i++)
			len2 += m[i] * m[i];
		// bitwise integer square root
		rem = len2;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		if (root == 0)
			root = 1;
		// rounded divide, sign put back afterwards
		for (i = 0; i < 4; i++) begin
			q = ((m[i] << FRAC_BITS) + (root >> 1)) / root;
			o[i] = (b[i] < 0) ? comp_t'(-q) : comp_t'(q);
		end
		r.out_x = o[0]; r.out_y = o[1]; r.out_z = o[2]; r.out_w = o[3];
		return r;
	endfunction

	function automatic comp_t rand_comp(int span);
		return comp_t'($urandom_range(0, 2 * span) - span);
	endfunction

	// one random item of the given kind
	function automatic operand_t make_item(item_kind_e kind);
		operand_t op;
		int       span;
		op.from_x = comp_t'($urandom); op.from_y = comp_t'($urandom);
		op.from_z = comp_t'($urandom); op.from_w = comp_t'($urandom);
		op.to_x   = comp_t'($urandom); op.to_y   = comp_t'($urandom);
		op.to_z   = comp_t'($urandom); op.to_w   = comp_t'($urandom);
		// mostly in range, sometimes the whole 17-bit field
		if ($urandom_range(0, 9) == 0)
			op.weight = WEIGHT_BITS'($urandom_range(0, CLIP_WEIGHT));
		else
			op.weight = WEIGHT_BITS'($urandom_range(0, WEIGHT_FULL));
		case (kind)
			KIND_UNITISH: begin
				span = 1 << FRAC_BITS;
				op.from_x = rand_comp(span); op.from_y = rand_comp(span);
				op.from_z = rand_comp(span); op.from_w = rand_comp(span);
				op.to_x   = rand_comp(span); op.to_y   = rand_comp(span);
				op.to_z   = rand_comp(span); op.to_w   = rand_comp(span);
			end
			KIND_OPPOSED: begin
				// near-opposite pair, drives the dot product negative
				op.to_x = -op.from_x + rand_comp(64);
				op.to_y = -op.from_y + rand_comp(64);
				op.to_z = -op.from_z + rand_comp(64);
				op.to_w = -op.from_w + rand_comp(64);
			end
			KIND_EDGE_WEIGHT: begin
				// hug the early-out boundaries of the current threshold
				if ($urandom_range(0, 1))
					op.weight = WEIGHT_BITS'(int'(edge_thr) + $urandom_range(0, 2) - 1);
				else
					op.weight = WEIGHT_BITS'(WEIGHT_FULL - int'(edge_thr)
						+ $urandom_range(0, 2) - 1);
			end
			default: ;
		endcase
		return op;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	// driver: one transfer per rising edge at most, gaps drawn per item
	always @(posedge clk or negedge arst_n) begin
		operand_t nxt;
		logic     take;
		if (!arst_n) begin
			start    <= 1'b0;
			operands <= '0;
			gap_left <= 0;
		end else begin
			take = start && !busy_s;
			if (take)
				expected_blends.push_back(nlerp_expect(operands, edge_thr));
			if (start && !take) begin
				// hold the current item until it is transferred
			end else if (gap_left > 0) begin
				start    <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_items.size() != 0) begin
				nxt = pending_items.pop_front();
				operands <= nxt;
				start    <= 1'b1;
				// some items go back to back even with gaps allowed
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_limit);
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		busy_s <= busy;
	end

	// monitor: a result strobe is compared with the oldest expectation
	always @(negedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_blends.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = expected_blends.pop_front();
				if (result.out_x !== want.out_x)
					report_mismatch("out_x", result.out_x, want.out_x);
				if (result.out_y !== want.out_y)
					report_mismatch("out_y", result.out_y, want.out_y);
				if (result.out_z !== want.out_z)
					report_mismatch("out_z", result.out_z, want.out_z);
				if (result.out_w !== want.out_w)
					report_mismatch("out_w", result.out_w, want.out_w);
				if (result.zero_length !== want.zero_length)
					report_mismatch("zero_length", result.zero_length, want.zero_length);
			end
		end
	end

	// waits until every queued item is transferred and every result is back
	task automatic drain();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || start || gap_left != 0
			|| expected_blends.size() != 0);
	endtask

	// threshold write over the cfg channel, only while the pipe is empty
	task automatic write_threshold(int value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= THR_BITS'(value);
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		edge_thr = THR_BITS'(value);
	endtask

	task automatic queue_random(int count);
		int k;
		for (k = 0; k < count; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: pending_items.push_back(make_item(KIND_ANY));
				3, 4, 5: pending_items.push_back(make_item(KIND_UNITISH));
				6, 7:    pending_items.push_back(make_item(KIND_OPPOSED));
				default: pending_items.push_back(make_item(KIND_EDGE_WEIGHT));
			endcase
		end
	endtask

	// directed corners at the reset threshold
	task automatic queue_directed();
		operand_t op;
		op = '0;
		op.weight = 32768;
		pending_items.push_back(op);            // all-zero blend
		op.weight = 0;
		pending_items.push_back(op);
		op = make_item(KIND_ANY);
		op.weight = 0;                           // low early out
		pending_items.push_back(op);
		op.weight = 1;                           // just at the threshold
		pending_items.push_back(op);
		op.weight = WEIGHT_FULL - 1;
		pending_items.push_back(op);
		op.weight = WEIGHT_FULL;
		pending_items.push_back(op);
		op.weight = WEIGHT_FULL + 1;             // out of range, high early out
		pending_items.push_back(op);
		op.weight = CLIP_WEIGHT;
		pending_items.push_back(op);
		// component extremes
		op = '0;
		op.from_x = comp_t'(-32768); op.from_y = comp_t'(-32768);
		op.from_z = comp_t'(-32768); op.from_w = comp_t'(-32768);
		op.to_x   = comp_t'(32767);  op.to_y   = comp_t'(32767);
		op.to_z   = comp_t'(32767);  op.to_w   = comp_t'(32767);
		op.weight = 32768;                       // negative dot product
		pending_items.push_back(op);
		op.to_x = comp_t'(-32768); op.to_y = comp_t'(-32768);
		op.to_z = comp_t'(-32768); op.to_w = comp_t'(-32768);
		pending_items.push_back(op);             // largest blend magnitude
		op = '0;
		op.from_w = comp_t'(1);
		op.weight = 2;                           // tiny blend, long left shift
		pending_items.push_back(op);
		op.to_x = comp_t'(1);
		op.weight = 40000;
		pending_items.push_back(op);
		op = '0;
		op.from_w = comp_t'(16384);
		op.to_w   = comp_t'(-16384);
		op.weight = 16384;                       // antipodal pair
		pending_items.push_back(op);
		op.to_w = comp_t'(16384);
		op.to_x = comp_t'(16384);
		pending_items.push_back(op);
	endtask

	initial begin
		int phase_thr[$];
		int p;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		edge_thr   = THR_RESET;
		gap_limit  = 0;
		error_count = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset threshold: corners back to back, then random with gaps
		queue_directed();
		drain();
		gap_limit = MAX_GAP;
		queue_random(250);
		drain();

		// zero, half, wide, and a few in between, then reset value again
		phase_thr = '{0, 32768, WIDE_THR, 32767, 1, 0, 0, 1};
		phase_thr[5] = $urandom_range(2, 4096);
		phase_thr[6] = $urandom_range(4097, 32768);
		for (p = 0; p < phase_thr.size(); p++) begin
			write_threshold(phase_thr[p]);
			gap_limit = (p % 2 == 0) ? MAX_GAP : 0;
			queue_random((p == 2 || p == 1) ? 80 : 230);
			drain();
		end

		repeat (LATENCY + 10) @(posedge clk);
		if (error_count == 0)
			$display("quaternion_nlerp_unit_tb: clean");
		else
			$display("quaternion_nlerp_unit_tb: errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("quaternion_nlerp_unit_tb: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/qnl_pkg.sv
hw/rtl/quaternion_nlerp_unit.sv
test/quaternion_nlerp_unit_tb.sv
